// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the range beeper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every rising edge of clk_i outside reset.
`define URB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("urb assertion failed");
// When the antecedent holds, the consequent must hold in the next clock cycle.
`define URB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("urb assertion failed");
`else
`define URB_ASSERT(lbl, prop)
`define URB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/urb_pkg.sv -----
// Package with the shared types and constants of the range beeper.
package urb_pkg;

  // Microsecond ticks in one millisecond.
  localparam int TICKS_PER_MS = 1000;

  localparam int DIST_W   = 10;
  localparam int DIST_MAX = 1023;

  // Width of a timer load value: a 16-bit rate times a 10-bit distance.
  localparam int IV_W = 26;

  // Longest pause in ticks, capped at 32 bits; the tick counter fits it.
  localparam longint PAUSE_RAW = 64'(65535) * 64'(TICKS_PER_MS);
  localparam longint PAUSE_CAP = (PAUSE_RAW > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : PAUSE_RAW;
  localparam int PT_RAW_W = $clog2(PAUSE_CAP + 1);
  localparam int PT_W     = (PT_RAW_W > 16) ? PT_RAW_W : 16;

  localparam int TPM_W = $clog2(TICKS_PER_MS + 1);
  localparam int PM_W  = 16 + TPM_W;
  localparam int PS_W  = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;

  typedef enum logic [2:0] {
    REG_TRIG_LEN    = 3'd0,
    REG_ECHO_TMO    = 3'd1,
    REG_PAUSE       = 3'd2,
    REG_SCALE       = 3'd3,
    REG_BUZ_ON      = 3'd4,
    REG_GAP_PER_CM  = 3'd5,
    REG_LED_PER_CM  = 3'd6,
    REG_ZERO_PERIOD = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [9:0]  trigger_len_us;
    logic [15:0] echo_timeout_us;
    logic [15:0] pause_ms;
    logic [15:0] scale_q16;
    logic [15:0] buzzer_on_ms;
    logic [15:0] gap_per_cm_ms;
    logic [15:0] led_per_cm_ms;
    logic [15:0] zero_period_ms;
  } cfg_t;

  // Ranging outcome of one tick.
  typedef struct packed {
    logic              trigger_out;
    logic              new_distance;
    logic              timed_out;
    logic [DIST_W-1:0] distance;
  } rng_res_t;

endpackage

// ----- rtl/urb_ifs.sv -----
// Valid/ready channel interfaces for the tick input and the result output.
interface urb_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink (input valid, input echo_level, output ready);
endinterface

interface urb_out_if import urb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              trigger_out;
  logic              buzzer_on;
  logic              led_on;
  logic [DIST_W-1:0] distance;
  logic              new_distance;
  logic              timed_out;

  modport source (output valid, output trigger_out, output buzzer_on, output led_on,
                  output distance, output new_distance, output timed_out, input ready);
  modport sink (input valid, input trigger_out, input buzzer_on, input led_on,
                input distance, input new_distance, input timed_out, output ready);
endinterface

// ----- rtl/urb_regs.sv -----
// APB configuration register file of the range beeper.
module urb_regs import urb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o,
  output cfg_t        cfg_next_o
);

  localparam cfg_t CFG_RESET = '{
    trigger_len_us:  10'd10,
    echo_timeout_us: 16'd50000,
    pause_ms:        16'd250,
    scale_q16:       16'd1124,
    buzzer_on_ms:    16'd500,
    gap_per_cm_ms:   16'd10,
    led_per_cm_ms:   16'd5000,
    zero_period_ms:  16'd1000
  };

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_TRIG_LEN:    cfg_d.trigger_len_us  = pwdata[9:0];
        REG_ECHO_TMO:    cfg_d.echo_timeout_us = pwdata[15:0];
        REG_PAUSE:       cfg_d.pause_ms        = pwdata[15:0];
        REG_SCALE:       cfg_d.scale_q16       = pwdata[15:0];
        REG_BUZ_ON:      cfg_d.buzzer_on_ms    = pwdata[15:0];
        REG_GAP_PER_CM:  cfg_d.gap_per_cm_ms   = pwdata[15:0];
        REG_LED_PER_CM:  cfg_d.led_per_cm_ms   = pwdata[15:0];
        REG_ZERO_PERIOD: cfg_d.zero_period_ms  = pwdata[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TRIG_LEN:    prdata = 32'(cfg_q.trigger_len_us);
      REG_ECHO_TMO:    prdata = 32'(cfg_q.echo_timeout_us);
      REG_PAUSE:       prdata = 32'(cfg_q.pause_ms);
      REG_SCALE:       prdata = 32'(cfg_q.scale_q16);
      REG_BUZ_ON:      prdata = 32'(cfg_q.buzzer_on_ms);
      REG_GAP_PER_CM:  prdata = 32'(cfg_q.gap_per_cm_ms);
      REG_LED_PER_CM:  prdata = 32'(cfg_q.led_per_cm_ms);
      REG_ZERO_PERIOD: prdata = 32'(cfg_q.zero_period_ms);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o      = cfg_q;
  assign cfg_next_o = cfg_d;

endmodule

// ----- rtl/urb_ranging.sv -----
// Trigger, listen and pause sequencer that measures the echo pulse.
module urb_ranging import urb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  logic     echo_i,
  input  cfg_t     cfg_i,
  input  cfg_t     cfg_next_i,
  output rng_res_t res_o
);

  typedef enum logic [1:0] {
    PH_TRIG   = 2'd0,
    PH_LISTEN = 2'd1,
    PH_PAUSE  = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [PT_W-1:0]   ticks_q, ticks_d, tick_inc;
  logic              seen_q, seen_d;
  logic [15:0]       pulse_q, pulse_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [DIST_W-1:0] cand_q, cand_d;
  logic [PT_W-1:0]   target_q, target_d;
  logic [31:0]       cand_prod;
  logic [15:0]       cand_hi;
  logic [PM_W-1:0]   pause_raw;
  logic [9:0]        trig_len;
  logic              trig, fresh, tmo;

  // The candidate distance always matches the stored pulse length, so a
  // completing pulse reads it from a register and no multiplier sits in
  // the tick path.
  assign cand_prod = 32'(pulse_d) * 32'(cfg_next_i.scale_q16);
  assign cand_hi   = cand_prod[31:16];
  assign cand_d    = (cand_hi > 16'(DIST_MAX)) ? DIST_W'(DIST_MAX) : cand_hi[DIST_W-1:0];

  // Pause length in ticks, at least one.
  always_comb begin
    pause_raw = PM_W'(cfg_next_i.pause_ms) * PM_W'(TICKS_PER_MS);
    if (pause_raw == '0) begin
      target_d = PT_W'(1);
    end else if (64'(pause_raw) > PAUSE_CAP) begin
      target_d = PT_W'(PAUSE_CAP);
    end else begin
      target_d = PT_W'(pause_raw);
    end
  end

  assign tick_inc = (ticks_q == '1) ? ticks_q : ticks_q + PT_W'(1);
  assign trig_len = (cfg_i.trigger_len_us == '0) ? 10'd1 : cfg_i.trigger_len_us;

  always_comb begin
    phase_d = phase_q;
    ticks_d = ticks_q;
    seen_d  = seen_q;
    pulse_d = pulse_q;
    dist_d  = dist_q;
    trig    = 1'b0;
    fresh   = 1'b0;
    tmo     = 1'b0;
    if (step_i) begin
      case (phase_q)
        PH_LISTEN: begin
          ticks_d = tick_inc;
          if (echo_i) begin
            if (!seen_q) begin
              seen_d  = 1'b1;
              pulse_d = 16'd1;
            end else if (pulse_q != 16'hFFFF) begin
              pulse_d = pulse_q + 16'd1;
            end
          end else if (seen_q) begin
            dist_d = cand_q;
            fresh  = 1'b1;
          end
          if (!fresh && (tick_inc >= PT_W'(cfg_i.echo_timeout_us))) begin
            tmo = 1'b1;
          end
          if (fresh || tmo) begin
            phase_d = PH_PAUSE;
            ticks_d = '0;
          end
        end
        PH_PAUSE: begin
          ticks_d = tick_inc;
          if (tick_inc >= target_q) begin
            phase_d = PH_TRIG;
            ticks_d = '0;
          end
        end
        default: begin
          // The trigger phase, and the spare phase code behaving as it.
          phase_d = PH_TRIG;
          trig    = 1'b1;
          ticks_d = tick_inc;
          if (tick_inc >= PT_W'(trig_len)) begin
            phase_d = PH_LISTEN;
            ticks_d = '0;
            seen_d  = 1'b0;
            pulse_d = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TRIG;
      ticks_q <= '0;
      seen_q  <= 1'b0;
      pulse_q <= '0;
      dist_q  <= '0;
    end else begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      seen_q  <= seen_d;
      pulse_q <= pulse_d;
      dist_q  <= dist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q   <= cand_d;
    target_q <= target_d;
  end

  assign res_o = '{trigger_out: trig, new_distance: fresh, timed_out: tmo, distance: dist_d};

endmodule

// ----- rtl/urb_timers.sv -----
// Millisecond prescaler with the buzzer and LED pacing timers.
module urb_timers import urb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [DIST_W-1:0] dist_i,
  input  cfg_t              cfg_i,
  output logic              buzzer_o,
  output logic              led_o
);

  logic [PS_W-1:0] presc_q, presc_d;
  logic            buz_lvl_q, buz_lvl_d;
  logic [IV_W-1:0] buz_left_q, buz_left_d;
  logic [IV_W-1:0] gap_q, gap_d;
  logic            gap_pend_q, gap_pend_d;
  logic [IV_W-1:0] gprod_q, gprod_d;
  logic            led_lvl_q, led_lvl_d;
  logic [IV_W-1:0] led_left_q, led_left_d;
  logic            led_pend_q, led_pend_d;
  logic [IV_W-1:0] lprod_q, lprod_d;
  logic [IV_W-1:0] eff_gap, eff_led_left, bl, ll;

  function automatic logic [IV_W-1:0] interval(input logic [IV_W-1:0] prod,
                                               input logic [15:0] zero_period);
    interval = (prod == '0) ? IV_W'(zero_period) : prod;
  endfunction

  // Rate times distance, registered every clock. A timer that fires marks its
  // load value pending; the product of the distance of that tick is ready
  // in the next clock cycle and is folded in then.
  assign gprod_d = IV_W'(cfg_i.gap_per_cm_ms) * IV_W'(dist_i);
  assign lprod_d = IV_W'(cfg_i.led_per_cm_ms) * IV_W'(dist_i);

  assign eff_gap      = gap_pend_q ? interval(gprod_q, cfg_i.zero_period_ms) : gap_q;
  assign eff_led_left = led_pend_q ? interval(lprod_q, cfg_i.zero_period_ms) : led_left_q;

  always_comb begin
    presc_d    = presc_q;
    buz_lvl_d  = buz_lvl_q;
    buz_left_d = buz_left_q;
    gap_d      = eff_gap;
    gap_pend_d = 1'b0;
    led_lvl_d  = led_lvl_q;
    led_left_d = eff_led_left;
    led_pend_d = 1'b0;
    bl         = buz_left_q;
    ll         = eff_led_left;
    if (step_i) begin
      if (int'(presc_q) + 1 >= TICKS_PER_MS) begin
        presc_d = '0;
        if (bl != '0) begin
          bl = bl - IV_W'(1);
        end
        if (ll != '0) begin
          ll = ll - IV_W'(1);
        end
      end else begin
        presc_d = presc_q + PS_W'(1);
      end
      if (bl == '0) begin
        if (!buz_lvl_q) begin
          buz_lvl_d  = 1'b1;
          gap_pend_d = 1'b1;
          bl         = IV_W'(cfg_i.buzzer_on_ms);
        end else begin
          buz_lvl_d = 1'b0;
          bl        = eff_gap;
        end
      end
      if (ll == '0) begin
        led_lvl_d  = ~led_lvl_q;
        led_pend_d = 1'b1;
      end
      buz_left_d = bl;
      led_left_d = ll;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q    <= '0;
      buz_lvl_q  <= 1'b0;
      buz_left_q <= '0;
      gap_q      <= '0;
      gap_pend_q <= 1'b0;
      led_lvl_q  <= 1'b0;
      led_left_q <= '0;
      led_pend_q <= 1'b0;
    end else begin
      presc_q    <= presc_d;
      buz_lvl_q  <= buz_lvl_d;
      buz_left_q <= buz_left_d;
      gap_q      <= gap_d;
      gap_pend_q <= gap_pend_d;
      led_lvl_q  <= led_lvl_d;
      led_left_q <= led_left_d;
      led_pend_q <= led_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gprod_q <= gprod_d;
    lprod_q <= lprod_d;
  end

  assign buzzer_o = buz_lvl_d;
  assign led_o    = led_lvl_d;

endmodule

// ----- rtl/ultrasonic_range_beeper.sv -----
// Top level of the ultrasonic range beeper: channels, input and result registers.
//
// Each transfer on in_i is one microsecond tick carrying the sampled echo
// level; each tick yields exactly one transfer on out_o with the trigger
// drive, buzzer and LED levels, the held distance in centimeters and the
// one-tick flags for a completed measurement and for a timeout.
// A tick taken sits in the input register until the result register is free,
// is processed by the ranging sequencer and the millisecond timers as it moves
// into the result register and is offered on out_o from then on. One tick is
// taken every clock while out_o is ready; the rate is set by the update of the
// ranging and timer state as each tick advances; its multipliers feed
// registers that always track the pulse length and held distance. When out_o
// stalls, the result register holds, the pending tick waits in the input
// register and in_i drops ready until the result is taken. Reset (rst_ni low,
// asynchronous) empties both registers, loads the configuration defaults and
// starts in the trigger phase with both timers due to fire on the first tick.
// No clearing pass is needed after reset. The user writes configuration over
// the APB port only while no tick is in flight; the block does not enforce it.
module ultrasonic_range_beeper import urb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  urb_in_if.sink      in_i,
  urb_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "assert_macros.svh"

  // Input register holding one accepted tick.
  logic s1_valid_q, s1_valid_d;
  logic s1_echo_q;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic              out_trig_q, out_buz_q, out_led_q, out_fresh_q, out_tmo_q;
  logic [DIST_W-1:0] out_dist_q;

  logic     adv, in_xfer;
  cfg_t     cfg, cfg_next;
  rng_res_t rng_res;
  logic     buz_lvl, led_lvl;

  // A tick advances when the result register is empty or being emptied.
  assign adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_xfer = in_i.valid && in_i.ready;

  assign in_i.ready = !s1_valid_q || adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  urb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg_o      (cfg),
    .cfg_next_o (cfg_next)
  );

  urb_ranging u_ranging (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (adv),
    .echo_i     (s1_echo_q),
    .cfg_i      (cfg),
    .cfg_next_i (cfg_next),
    .res_o      (rng_res)
  );

  // The timers see the distance as updated by the same tick.
  urb_timers u_timers (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .dist_i   (rng_res.distance),
    .cfg_i    (cfg),
    .buzzer_o (buz_lvl),
    .led_o    (led_lvl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_echo_q <= in_i.echo_level;
    end
    if (adv) begin
      out_trig_q  <= rng_res.trigger_out;
      out_buz_q   <= buz_lvl;
      out_led_q   <= led_lvl;
      out_dist_q  <= rng_res.distance;
      out_fresh_q <= rng_res.new_distance;
      out_tmo_q   <= rng_res.timed_out;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.trigger_out  = out_trig_q;
  assign out_o.buzzer_on    = out_buz_q;
  assign out_o.led_on       = out_led_q;
  assign out_o.distance     = out_dist_q;
  assign out_o.new_distance = out_fresh_q;
  assign out_o.timed_out    = out_tmo_q;

  // A processed tick always leaves a result to be taken.
  `URB_ASSERT_NEXT(a_adv_fills_result, adv, out_valid_q)
  // A tick that cannot advance stays in the input register.
  `URB_ASSERT_NEXT(a_waiting_tick_kept, s1_valid_q && !adv, s1_valid_q)
  // A measurement never completes and times out on the same tick.
  `URB_ASSERT(a_flags_exclusive, !(rng_res.new_distance && rng_res.timed_out))

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the ultrasonic range beeper, with echo traffic and a tick model.
module tb import urb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Ranging phase of the tick model; the block never leaves these three codes.
  typedef enum logic [1:0] {
    RS_TRIGGER = 2'd0,
    RS_LISTEN  = 2'd1,
    RS_PAUSE   = 2'd2
  } range_stage_e;

  // One result transfer as seen on out_o.
  typedef struct packed {
    logic              trigger_out;
    logic              buzzer_on;
    logic              led_on;
    logic [DIST_W-1:0] distance;
    logic              new_distance;
    logic              timed_out;
  } tick_res_t;

  bit          clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  urb_in_if  in_bus ();
  urb_out_if out_bus ();

  ultrasonic_range_beeper dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Echo samples waiting to be offered, and the results predicted for the
  // ticks that the block has already taken, oldest first.
  bit        echo_q[$];
  tick_res_t predicted_q[$];

  bit tick_taken;
  bit idle_on;
  bit stall_req;
  bit hold_off;
  int send_gap;
  int recv_gap;
  int err_cnt;

  // Shadow of the configuration registers and of the block's own state.
  cfg_t              range_cfg;
  range_stage_e      stage;
  logic [31:0]       stage_ticks;
  logic              rise_seen;
  logic [15:0]       pulse_len;
  logic [DIST_W-1:0] dist_cm;
  logic [9:0]        ms_div;
  logic              buz_lvl;
  logic [31:0]       buz_left;
  logic [31:0]       buz_gap;
  logic              led_lvl;
  logic [31:0]       led_left;

  // 10 ns clock: high half, then low half.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void reset_model();
    range_cfg = '{trigger_len_us: 10'd10, echo_timeout_us: 16'd50000, pause_ms: 16'd250,
                  scale_q16: 16'd1124, buzzer_on_ms: 16'd500, gap_per_cm_ms: 16'd10,
                  led_per_cm_ms: 16'd5000, zero_period_ms: 16'd1000};
    stage       = RS_TRIGGER;
    stage_ticks = '0;
    rise_seen   = 1'b0;
    pulse_len   = '0;
    dist_cm     = '0;
    ms_div      = '0;
    buz_lvl     = 1'b0;
    buz_left    = '0;
    buz_gap     = '0;
    led_lvl     = 1'b0;
    led_left    = '0;
  endfunction

  // The phase tick counter sticks at its top value instead of wrapping.
  function automatic void bump_ticks();
    if (stage_ticks != 32'hFFFF_FFFF) stage_ticks++;
  endfunction

  // Timer reload: a per-centimeter rate times the held distance, with the
  // fallback interval standing in when the product is zero.
  function automatic logic [IV_W-1:0] reload_for(input logic [15:0] per_cm);
    logic [IV_W-1:0] iv;
    iv = per_cm * dist_cm;
    return (iv != '0) ? iv : IV_W'(range_cfg.zero_period_ms);
  endfunction

  // Advances the model by one microsecond tick and returns the result that
  // the block must show for it. Ranging goes first, so the timers see a
  // distance measured on this same tick.
  function automatic tick_res_t range_step(input logic echo);
    tick_res_t       r;
    logic [31:0]     prod;
    logic [9:0]      len;
    longint unsigned target;
    r = '0;
    case (stage)
      RS_LISTEN: begin
        bump_ticks();
        if (echo) begin
          // A level already high when listening starts counts as the rise.
          if (!rise_seen) begin
            rise_seen = 1'b1;
            pulse_len = 16'd1;
          end else if (pulse_len != 16'hFFFF) begin
            pulse_len++;
          end
        end else if (rise_seen) begin
          prod = pulse_len * range_cfg.scale_q16;
          dist_cm = (prod[31:16] > DIST_MAX) ? DIST_W'(DIST_MAX) : prod[16 +: DIST_W];
          r.new_distance = 1'b1;
        end
        if (!r.new_distance && stage_ticks >= 32'(range_cfg.echo_timeout_us))
          r.timed_out = 1'b1;
        if (r.new_distance || r.timed_out) begin
          stage = RS_PAUSE;
          stage_ticks = '0;
        end
      end
      RS_PAUSE: begin
        target = 64'(range_cfg.pause_ms) * 64'(TICKS_PER_MS);
        if (target == 0) target = 1;
        if (target > 64'hFFFF_FFFF) target = 64'hFFFF_FFFF;
        bump_ticks();
        if (64'(stage_ticks) >= target) begin
          stage = RS_TRIGGER;
          stage_ticks = '0;
        end
      end
      default: begin
        // A zero trigger length still gives a trigger of one tick.
        len = (range_cfg.trigger_len_us != '0) ? range_cfg.trigger_len_us : 10'd1;
        stage = RS_TRIGGER;
        r.trigger_out = 1'b1;
        bump_ticks();
        if (stage_ticks >= 32'(len)) begin
          stage = RS_LISTEN;
          stage_ticks = '0;
          rise_seen = 1'b0;
          pulse_len = '0;
        end
      end
    endcase

    // Millisecond timers: counters drop once per millisecond wrap, and a
    // counter at zero fires on every tick until it is reloaded nonzero.
    if (ms_div + 1 >= TICKS_PER_MS) begin
      ms_div = '0;
      if (buz_left != 0) buz_left--;
      if (led_left != 0) led_left--;
    end else begin
      ms_div++;
    end
    if (buz_left == 0) begin
      if (!buz_lvl) begin
        buz_lvl  = 1'b1;
        buz_gap  = 32'(reload_for(range_cfg.gap_per_cm_ms));
        buz_left = 32'(range_cfg.buzzer_on_ms);
      end else begin
        buz_lvl  = 1'b0;
        buz_left = buz_gap;
      end
    end
    if (led_left == 0) begin
      led_lvl  = !led_lvl;
      led_left = 32'(reload_for(range_cfg.led_per_cm_ms));
    end

    r.buzzer_on = buz_lvl;
    r.led_on    = led_lvl;
    r.distance  = dist_cm;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DIST_W-1:0] want,
                             input logic [DIST_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Input side: a new sample goes out after the previous one was taken,
  // optionally after a short random gap.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_bus.valid || tick_taken)) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_bus.valid <= 1'b0;
      end else if (echo_q.size() != 0) begin
        in_bus.valid <= 1'b1;
        in_bus.echo_level <= echo_q[0];
        if (idle_on && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 8);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Output side: ready drops in random bursts, and for the long hold-off.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) begin
      out_bus.ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 8);
    end
  end

  // Every transfer in is run through the model at once; every transfer out
  // is held against the oldest prediction.
  always @(posedge clk_i) begin : monitor
    tick_res_t want;
    tick_taken <= rst_ni && in_bus.valid && in_bus.ready;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        void'(echo_q.pop_front());
        predicted_q.push_back(range_step(in_bus.echo_level));
      end
      if (out_bus.valid && out_bus.ready) begin
        if (predicted_q.size() == 0) begin
          $error("result transfer with no tick outstanding");
          err_cnt++;
        end else begin
          want = predicted_q.pop_front();
          check_field("trigger_out", want.trigger_out, out_bus.trigger_out);
          check_field("buzzer_on", want.buzzer_on, out_bus.buzzer_on);
          check_field("led_on", want.led_on, out_bus.led_on);
          check_field("distance", want.distance, out_bus.distance);
          check_field("new_distance", want.new_distance, out_bus.new_distance);
          check_field("timed_out", want.timed_out, out_bus.timed_out);
        end
      end
    end
  end

  // The long hold-off on the result side, counted here so that the sender
  // keeps offering while the block fills and drops its input ready.
  initial begin : result_hold
    wait (stall_req);
    hold_off = 1'b1;
    repeat (64) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // APB write: setup cycle, then access cycle; the register takes the value
  // at the edge inside the access cycle, since pready is always high.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_TRIG_LEN:    range_cfg.trigger_len_us  = val[9:0];
      REG_ECHO_TMO:    range_cfg.echo_timeout_us = val[15:0];
      REG_PAUSE:       range_cfg.pause_ms        = val[15:0];
      REG_SCALE:       range_cfg.scale_q16       = val[15:0];
      REG_BUZ_ON:      range_cfg.buzzer_on_ms    = val[15:0];
      REG_GAP_PER_CM:  range_cfg.gap_per_cm_ms   = val[15:0];
      REG_LED_PER_CM:  range_cfg.led_per_cm_ms   = val[15:0];
      REG_ZERO_PERIOD: range_cfg.zero_period_ms  = val[15:0];
      default:         range_cfg = range_cfg;
    endcase
  endtask

  function automatic void push_run(input bit lvl, input int n);
    repeat (n) echo_q.push_back(lvl);
  endfunction

  // Echo traffic: mostly clean pulses (low stretch, then high stretch) so
  // that measurements complete, mixed with short bursts of random noise.
  function automatic void queue_echo(input int n, input int low_max, input int high_max);
    int pushed;
    int lo;
    int hi;
    pushed = 0;
    while (pushed < n) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          echo_q.push_back($urandom_range(0, 1));
          pushed++;
        end
      end else begin
        lo = $urandom_range(0, low_max);
        hi = $urandom_range(1, high_max);
        push_run(1'b0, lo);
        push_run(1'b1, hi);
        pushed += lo + hi;
      end
    end
  endfunction

  // Waits until every tick has been taken and its result has come back, so
  // that the block is idle before a register write.
  task automatic drain();
    while (echo_q.size() != 0 || predicted_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [11:0] short_pat;
    in_bus.valid      = 1'b0;
    in_bus.echo_level = 1'b0;
    out_bus.ready     = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    rst_ni            = 1'b0;
    idle_on           = 1'b1;
    reset_model();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: both timers fire on the first tick, the echo is
    // already high when listening starts, and a two-tick pulse completes.
    push_run(1'b0, 8);
    push_run(1'b1, 4);
    push_run(1'b0, 1);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    drain();

    // Zero trigger length, zero timeout and zero pause each last one tick;
    // zero timer reloads make both timers fire on every tick.
    write_reg(REG_TRIG_LEN, 32'd0);
    write_reg(REG_ECHO_TMO, 32'd0);
    write_reg(REG_PAUSE, 32'd0);
    write_reg(REG_SCALE, 32'd65535);
    write_reg(REG_BUZ_ON, 32'd0);
    write_reg(REG_GAP_PER_CM, 32'd0);
    write_reg(REG_LED_PER_CM, 32'd0);
    write_reg(REG_ZERO_PERIOD, 32'd0);
    short_pat = 12'b1101_1100_1011;
    for (int i = 0; i < 12; i++) echo_q.push_back(short_pat[i]);
    drain();

    // Trigger length written with its upper bits set (they are dropped),
    // longest timeout and pause, full scale, and a clean pulse measured.
    write_reg(REG_TRIG_LEN, 32'hFFFF_FC03);
    write_reg(REG_ECHO_TMO, 32'd65535);
    write_reg(REG_PAUSE, 32'd65535);
    write_reg(REG_SCALE, 32'd65535);
    push_run(1'b0, 6);
    push_run(1'b1, 60);
    push_run(1'b0, 1);
    for (int i = 0; i < 5; i++) echo_q.push_back($urandom_range(0, 1));
    drain();

    // Random settings with short ranging cycles so that most ticks land in
    // the listen phase; one phase has a real millisecond pause.
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_TRIG_LEN, $urandom_range(0, 15));
      write_reg(REG_ECHO_TMO, $urandom_range(0, 120));
      write_reg(REG_PAUSE, (p == 3) ? 32'd1 : 32'd0);
      case ($urandom_range(0, 3))
        0:       write_reg(REG_SCALE, 32'd0);
        1:       write_reg(REG_SCALE, 32'd65535);
        default: write_reg(REG_SCALE, $urandom_range(0, 65535));
      endcase
      write_reg(REG_BUZ_ON, $urandom_range(0, 3));
      write_reg(REG_GAP_PER_CM, $urandom_range(0, 1));
      write_reg(REG_LED_PER_CM, $urandom_range(0, 1));
      write_reg(REG_ZERO_PERIOD, $urandom_range(0, 4));
      idle_on = (p != 2);
      queue_echo(40, 12, 24);
      if (p == 1) stall_req = 1'b1;
      drain();
    end

    // Last stretch without idling: shortest ranging settings and the largest
    // buzzer-on, gap and fallback values, so both timers latch long reloads.
    idle_on = 1'b0;
    write_reg(REG_TRIG_LEN, 32'd1);
    write_reg(REG_ECHO_TMO, 32'd1);
    write_reg(REG_PAUSE, 32'd0);
    write_reg(REG_SCALE, 32'd32768);
    write_reg(REG_BUZ_ON, 32'd65535);
    write_reg(REG_GAP_PER_CM, 32'd65535);
    write_reg(REG_LED_PER_CM, 32'd0);
    write_reg(REG_ZERO_PERIOD, 32'd65535);
    queue_echo(150, 3, 6);
    drain();

    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of a few hundred ticks.
  initial begin : watchdog
    #(5_000_000);
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ----- ultrasonic_range_beeper.f -----
+incdir+rtl
rtl/urb_pkg.sv
rtl/urb_ifs.sv
rtl/urb_regs.sv
rtl/urb_ranging.sv
rtl/urb_timers.sv
rtl/ultrasonic_range_beeper.sv
verif/tb.sv
